// ===== design/bfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bfd_pkg;

  // configuration register widths
  localparam int CFG_W     = 11;
  localparam int RATIO_W   = 3;
  localparam int SHAMT_W   = 4;

  // apb address decode
  localparam int ADDR_W    = 4;
  localparam int REG_IDX_W = 2;
  localparam int APB_DW    = 32;

  localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RATIO_LOG2 = 2'd2;

  localparam logic [CFG_W-1:0]   RST_SRC_WIDTH  = 11'd1024;
  localparam logic [CFG_W-1:0]   RST_SRC_HEIGHT = 11'd1024;
  localparam logic [RATIO_W-1:0] RST_RATIO_LOG2 = 3'd3;

  // rows are fixed to at most this many
  localparam int ROW_W = 10;
  localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 11'd1024;

  // pixel and sum layout
  localparam int NUM_CH = 4;
  localparam int CH_W   = 8;
  localparam int SUM_W  = 18;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_ALPHA = 3;

  typedef logic [NUM_CH-1:0][CH_W-1:0]  pix_t;
  typedef logic [NUM_CH-1:0][SUM_W-1:0] sums_t;

  // per-pixel control from position tracking to the accumulator
  typedef struct packed {
    logic               hit;    // pixel lies inside a whole block
    logic               first;  // top-left pixel of its block
    logic               last;   // bottom-right pixel of its block
    logic               lof;    // last pixel of the bottom-right block of the frame
    logic [SHAMT_W-1:0] shamt;  // 2 * ratio_log2
  } ctl_t;

endpackage

`default_nettype wire

// ===== design/bfd_pos.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfd_pos #(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_RATIO_LOG2 = 5,
  localparam int COLW          = $clog2(MAX_WIDTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic                        sof_i,
  input  wire logic [bfd_pkg::CFG_W-1:0]   cfg_width_i,
  input  wire logic [bfd_pkg::CFG_W-1:0]   cfg_height_i,
  input  wire logic [bfd_pkg::RATIO_W-1:0] cfg_ratio_i,
  output      logic [COLW-1:0]             idx_o,
  output      bfd_pkg::ctl_t               ctl_o
);

  localparam int WW = ($clog2(MAX_WIDTH + 1) > bfd_pkg::CFG_W) ?
                      $clog2(MAX_WIDTH + 1) : bfd_pkg::CFG_W;

  logic [COLW-1:0]                col_q, col_d;
  logic [bfd_pkg::ROW_W-1:0]      row_q, row_d;
  logic [WW-1:0]                  w_ext, w, wb, col_ext, col_inc;
  logic [bfd_pkg::CFG_W-1:0]      h, hb, row_ext, row_inc;
  logic [bfd_pkg::RATIO_W-1:0]    r;
  logic [COLW-1:0]                col, xmask;
  logic [bfd_pkg::ROW_W-1:0]      row, ymask;

  // clamp the configured sizes
  always_comb begin
    w_ext = WW'(cfg_width_i);
    if (w_ext == '0) begin
      w = WW'(1);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = w_ext;
    end
    if (cfg_height_i == '0) begin
      h = bfd_pkg::CFG_W'(1);
    end else if (cfg_height_i > bfd_pkg::HEIGHT_LIMIT) begin
      h = bfd_pkg::HEIGHT_LIMIT;
    end else begin
      h = cfg_height_i;
    end
    if (cfg_ratio_i > bfd_pkg::RATIO_W'(MAX_RATIO_LOG2)) begin
      r = bfd_pkg::RATIO_W'(MAX_RATIO_LOG2);
    end else begin
      r = cfg_ratio_i;
    end
    wb = (w >> r) << r;
    hb = (h >> r) << r;
  end

  // classify the current pixel
  always_comb begin
    col     = sof_i ? '0 : col_q;
    row     = sof_i ? '0 : row_q;
    col_ext = WW'(col);
    row_ext = bfd_pkg::CFG_W'(row);
    xmask   = ~({COLW{1'b1}} << r);
    ymask   = ~({bfd_pkg::ROW_W{1'b1}} << r);

    idx_o       = col >> r;
    ctl_o.hit   = (col_ext < wb) && (row_ext < hb);
    ctl_o.first = ((col & xmask) == '0) && ((row & ymask) == '0);
    ctl_o.last  = ((col & xmask) == xmask) && ((row & ymask) == ymask);
    ctl_o.lof   = (col_ext == wb - WW'(1)) && (row_ext == hb - bfd_pkg::CFG_W'(1));
    ctl_o.shamt = {r, 1'b0};
  end

  // raster advance with wrap at the frame end
  always_comb begin
    col_inc = col_ext + WW'(1);
    row_inc = row_ext;
    if (col_inc >= w) begin
      col_d   = '0;
      row_inc = row_ext + bfd_pkg::CFG_W'(1);
    end else begin
      col_d = col_inc[COLW-1:0];
    end
    if (row_inc >= h) begin
      row_d = '0;
    end else begin
      row_d = row_inc[bfd_pkg::ROW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/bfd_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfd_accum #(
  parameter int MAX_WIDTH = 1024,
  localparam int COLW     = $clog2(MAX_WIDTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [COLW-1:0] idx_i,
  input  wire bfd_pkg::ctl_t ctl_i,
  input  wire bfd_pkg::pix_t px_i,
  input  wire logic          advance_i,
  output      logic          busy_o,
  output      logic          res_valid_o,
  output      bfd_pkg::pix_t res_px_o,
  output      logic          res_lof_o
);

  // column sums, one entry per block column
  bfd_pkg::sums_t sum_mem [MAX_WIDTH];

  logic             s1_valid_q, s1_valid_d;
  logic             fwd_hit_q, fwd_hit_d;
  logic [COLW-1:0]  s1_idx_q;
  bfd_pkg::ctl_t    s1_ctl_q;
  bfd_pkg::pix_t    s1_px_q;
  bfd_pkg::sums_t   rdata_q;
  bfd_pkg::sums_t   last_sum_q;
  bfd_pkg::sums_t   base, sum;
  logic             wr_en;

  // an accepted pixel finds the stage empty or leaving, so the item in it
  // writes at that same edge; its sum is forwarded when the entry matches
  always_comb begin
    s1_valid_d = accept_i || (s1_valid_q && !advance_i);
    fwd_hit_d  = s1_valid_q && s1_ctl_q.hit && (s1_idx_q == idx_i);
    wr_en      = s1_valid_q && s1_ctl_q.hit && advance_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept_i) begin
        fwd_hit_q <= fwd_hit_d;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_idx_q   <= idx_i;
      s1_ctl_q   <= ctl_i;
      s1_px_q    <= px_i;
      last_sum_q <= sum;
    end
  end

  // sum memory: read on transfer, write back when the stage moves on
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rdata_q <= sum_mem[idx_i];
    end
    if (wr_en) begin
      sum_mem[s1_idx_q] <= sum;
    end
  end

  // accumulate and scale
  always_comb begin
    base = fwd_hit_q ? last_sum_q : rdata_q;
    for (int c = 0; c < bfd_pkg::NUM_CH; c++) begin
      if (s1_ctl_q.first) begin
        sum[c] = bfd_pkg::SUM_W'(s1_px_q[c]);
      end else begin
        sum[c] = base[c] + bfd_pkg::SUM_W'(s1_px_q[c]);
      end
      res_px_o[c] = bfd_pkg::CH_W'(sum[c] >> s1_ctl_q.shamt);
    end
  end

  assign busy_o      = s1_valid_q;
  assign res_valid_o = s1_valid_q && s1_ctl_q.hit && s1_ctl_q.last;
  assign res_lof_o   = s1_ctl_q.lof;

endmodule

`default_nettype wire

// ===== design/box_filter_downscaler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                payload
// in        input      in_valid_i / in_stall_o  in_red/green/blue/alpha, start_of_frame
// out       output     out_valid_o / out_stall_i out_red/green/blue/alpha, last_of_frame
// cfg       input      apb psel/penable/pready  src_width, src_height, ratio_log2
//
// one pixel per cycle sustained while the output is not stalled; a block's result goes
// from the stage register to the output register and waits there while the output stalls
// the column-sum memory is read at the transfer and written when the pixel leaves
// the stage; a pixel hitting the entry still in flight takes the forwarded sum
// reset clears positions and handshake state; the sum memory is not cleared
// in_stall_o is high only while the output register is full and stalled

module box_filter_downscaler #(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_RATIO_LOG2 = 5
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // apb configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bfd_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bfd_pkg::APB_DW-1:0]   pwdata,
  output      logic [bfd_pkg::APB_DW-1:0]   prdata,
  output      logic                         pready,
  // input pixels
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic [bfd_pkg::CH_W-1:0]     in_red_i,
  input  wire logic [bfd_pkg::CH_W-1:0]     in_green_i,
  input  wire logic [bfd_pkg::CH_W-1:0]     in_blue_i,
  input  wire logic [bfd_pkg::CH_W-1:0]     in_alpha_i,
  input  wire logic                         start_of_frame_i,
  // output pixels
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic [bfd_pkg::CH_W-1:0]     out_red_o,
  output      logic [bfd_pkg::CH_W-1:0]     out_green_o,
  output      logic [bfd_pkg::CH_W-1:0]     out_blue_o,
  output      logic [bfd_pkg::CH_W-1:0]     out_alpha_o,
  output      logic                         last_of_frame_o
);

  localparam int COLW = $clog2(MAX_WIDTH);

  logic [bfd_pkg::CFG_W-1:0]     src_width_q, src_height_q;
  logic [bfd_pkg::RATIO_W-1:0]   ratio_log2_q;
  logic [bfd_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;

  logic                          accept, advance, busy;
  logic [COLW-1:0]               idx;
  bfd_pkg::ctl_t                 ctl;
  bfd_pkg::pix_t                 in_px, res_px;
  logic                          res_valid, res_lof;

  logic                          out_valid_q, out_valid_d;
  bfd_pkg::pix_t                 out_px_q;
  logic                          out_lof_q;

  // configuration registers
  assign reg_idx = paddr[bfd_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= bfd_pkg::RST_SRC_WIDTH;
      src_height_q <= bfd_pkg::RST_SRC_HEIGHT;
      ratio_log2_q <= bfd_pkg::RST_RATIO_LOG2;
    end else if (cfg_wr) begin
      case (reg_idx)
        bfd_pkg::REG_SRC_WIDTH:  src_width_q  <= pwdata[bfd_pkg::CFG_W-1:0];
        bfd_pkg::REG_SRC_HEIGHT: src_height_q <= pwdata[bfd_pkg::CFG_W-1:0];
        bfd_pkg::REG_RATIO_LOG2: ratio_log2_q <= pwdata[bfd_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      bfd_pkg::REG_SRC_WIDTH:  prdata = bfd_pkg::APB_DW'(src_width_q);
      bfd_pkg::REG_SRC_HEIGHT: prdata = bfd_pkg::APB_DW'(src_height_q);
      bfd_pkg::REG_RATIO_LOG2: prdata = bfd_pkg::APB_DW'(ratio_log2_q);
      default:                 prdata = '0;
    endcase
  end

  // handshake: the pipeline stage moves whenever the output register can load
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_px                   = '0;
    in_px[bfd_pkg::CH_RED]   = in_red_i;
    in_px[bfd_pkg::CH_GREEN] = in_green_i;
    in_px[bfd_pkg::CH_BLUE]  = in_blue_i;
    in_px[bfd_pkg::CH_ALPHA] = in_alpha_i;
  end

  bfd_pos #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_RATIO_LOG2 (MAX_RATIO_LOG2)
  ) u_pos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .sof_i        (start_of_frame_i),
    .cfg_width_i  (src_width_q),
    .cfg_height_i (src_height_q),
    .cfg_ratio_i  (ratio_log2_q),
    .idx_o        (idx),
    .ctl_o        (ctl)
  );

  bfd_accum #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .idx_i       (idx),
    .ctl_i       (ctl),
    .px_i        (in_px),
    .advance_i   (advance),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_px_o    (res_px),
    .res_lof_o   (res_lof)
  );

  // output register
  assign out_valid_d = advance ? (busy && res_valid) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_px_q  <= res_px;
      out_lof_q <= res_lof;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_red_o       = out_px_q[bfd_pkg::CH_RED];
  assign out_green_o     = out_px_q[bfd_pkg::CH_GREEN];
  assign out_blue_o      = out_px_q[bfd_pkg::CH_BLUE];
  assign out_alpha_o     = out_px_q[bfd_pkg::CH_ALPHA];
  assign last_of_frame_o = out_lof_q;

endmodule

`default_nettype wire

// ===== design/bfd_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfd_chk (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_stall_o,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic [bfd_pkg::CH_W-1:0] out_red_o,
  input wire logic [bfd_pkg::CH_W-1:0] out_green_o,
  input wire logic [bfd_pkg::CH_W-1:0] out_blue_o,
  input wire logic [bfd_pkg::CH_W-1:0] out_alpha_o,
  input wire logic                     last_of_frame_o
);

  // input back-pressure only comes from a full, stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // a new result follows an input transfer through the stage and output registers
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result appeared without a matching input transfer");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_red_o) && $stable(out_green_o) &&
       $stable(out_blue_o) && $stable(out_alpha_o) && $stable(last_of_frame_o)))
    else $error("stalled result changed");

endmodule

bind box_filter_downscaler bfd_chk u_bfd_chk (.*);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int LINE_DEPTH    = 1024;
  localparam int RATIO_CAP     = 5;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 150;

  typedef struct packed {
    logic [bfd_pkg::CH_W-1:0] red;
    logic [bfd_pkg::CH_W-1:0] green;
    logic [bfd_pkg::CH_W-1:0] blue;
    logic [bfd_pkg::CH_W-1:0] alpha;
    logic                     sof;
  } src_pix_t;

  typedef struct packed {
    logic [bfd_pkg::CH_W-1:0] red;
    logic [bfd_pkg::CH_W-1:0] green;
    logic [bfd_pkg::CH_W-1:0] blue;
    logic [bfd_pkg::CH_W-1:0] alpha;
    logic                     lof;
  } out_pix_t;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // box average predictor and queue of expected output pixels
  class downscale_checker;
    logic [bfd_pkg::CFG_W-1:0]   width_reg;
    logic [bfd_pkg::CFG_W-1:0]   height_reg;
    logic [bfd_pkg::RATIO_W-1:0] ratio_reg;
    logic [bfd_pkg::SUM_W-1:0]   col_sums [bfd_pkg::NUM_CH][LINE_DEPTH];
    int unsigned                 col_pos;
    int unsigned                 row_pos;
    out_pix_t                    pending_means[$];
    int                          fails;

    function new();
      width_reg  = bfd_pkg::RST_SRC_WIDTH;
      height_reg = bfd_pkg::RST_SRC_HEIGHT;
      ratio_reg  = bfd_pkg::RST_RATIO_LOG2;
      col_pos    = 0;
      row_pos    = 0;
      fails      = 0;
    endfunction

    function void write_reg(input logic [bfd_pkg::REG_IDX_W-1:0] idx,
                            input logic [bfd_pkg::CFG_W-1:0] value);
      case (idx)
        bfd_pkg::REG_SRC_WIDTH:  width_reg = value;
        bfd_pkg::REG_SRC_HEIGHT: height_reg = value;
        bfd_pkg::REG_RATIO_LOG2: ratio_reg = value[bfd_pkg::RATIO_W-1:0];
        default: ;
      endcase
    endfunction

    // accumulate one accepted pixel, queue the mean when a block completes
    function void take_pixel(input src_pix_t p);
      logic [bfd_pkg::CH_W-1:0]  chan [bfd_pkg::NUM_CH];
      logic [bfd_pkg::CH_W-1:0]  mean [bfd_pkg::NUM_CH];
      logic [bfd_pkg::SUM_W-1:0] s;
      int unsigned               w, h, r, side, wb, hb, col, row, idx;
      bit                        first_px, last_px;
      int                        c;
      out_pix_t                  m;
      chan[bfd_pkg::CH_RED]   = p.red;
      chan[bfd_pkg::CH_GREEN] = p.green;
      chan[bfd_pkg::CH_BLUE]  = p.blue;
      chan[bfd_pkg::CH_ALPHA] = p.alpha;
      // sizes of zero count as one, larger ones saturate
      w = (width_reg == 0) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
      h = (height_reg == 0) ? 1 :
          ((height_reg > bfd_pkg::HEIGHT_LIMIT) ? bfd_pkg::HEIGHT_LIMIT : height_reg);
      r = (ratio_reg > RATIO_CAP) ? RATIO_CAP : ratio_reg;
      side = 1 << r;
      wb = (w >> r) << r;
      hb = (h >> r) << r;
      if (p.sof) begin
        col_pos = 0;
        row_pos = 0;
      end
      col = col_pos;
      row = row_pos;
      if (col < wb && row < hb) begin
        first_px = ((col % side) == 0) && ((row % side) == 0);
        last_px  = ((col % side) == side - 1) && ((row % side) == side - 1);
        idx = (col >> r) % LINE_DEPTH;
        for (c = 0; c < bfd_pkg::NUM_CH; c++) begin
          s = first_px ? bfd_pkg::SUM_W'(chan[c]) :
                         col_sums[c][idx] + bfd_pkg::SUM_W'(chan[c]);
          col_sums[c][idx] = s;
          mean[c] = bfd_pkg::CH_W'(s >> (2 * r));
        end
        if (last_px) begin
          m.red   = mean[bfd_pkg::CH_RED];
          m.green = mean[bfd_pkg::CH_GREEN];
          m.blue  = mean[bfd_pkg::CH_BLUE];
          m.alpha = mean[bfd_pkg::CH_ALPHA];
          m.lof   = (col == wb - 1) && (row == hb - 1);
          pending_means.push_back(m);
        end
      end
      // advance in raster order, wrapping at the frame end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
      if (row >= h) row = 0;
      col_pos = col;
      row_pos = row;
    endfunction

    // compare one output transfer against the oldest expected mean
    function void match_pixel(input out_pix_t got);
      out_pix_t want;
      if (pending_means.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected output pixel r=%0d g=%0d b=%0d a=%0d last=%0b",
                   got.red, got.green, got.blue, got.alpha, got.lof);
      end else begin
        want = pending_means.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.lof !== want.lof) begin
          fails++;
          if (fails <= 10)
            $display({"mismatch: expected r=%0d g=%0d b=%0d a=%0d last=%0b, ",
                      "got r=%0d g=%0d b=%0d a=%0d last=%0b"},
                     want.red, want.green, want.blue, want.alpha, want.lof,
                     got.red, got.green, got.blue, got.alpha, got.lof);
        end
      end
    endfunction
  endclass

  logic                         clk_i            = 1'b0;
  logic                         rst_ni           = 1'b0;
  logic                         psel             = 1'b0;
  logic                         penable          = 1'b0;
  logic                         pwrite           = 1'b0;
  logic [bfd_pkg::ADDR_W-1:0]   paddr            = '0;
  logic [bfd_pkg::APB_DW-1:0]   pwdata           = '0;
  logic [bfd_pkg::APB_DW-1:0]   prdata;
  logic                         pready;
  logic                         in_valid_i       = 1'b0;
  logic                         in_stall_o;
  logic [bfd_pkg::CH_W-1:0]     in_red_i         = '0;
  logic [bfd_pkg::CH_W-1:0]     in_green_i       = '0;
  logic [bfd_pkg::CH_W-1:0]     in_blue_i        = '0;
  logic [bfd_pkg::CH_W-1:0]     in_alpha_i       = '0;
  logic                         start_of_frame_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i      = 1'b0;
  logic [bfd_pkg::CH_W-1:0]     out_red_o;
  logic [bfd_pkg::CH_W-1:0]     out_green_o;
  logic [bfd_pkg::CH_W-1:0]     out_blue_o;
  logic [bfd_pkg::CH_W-1:0]     out_alpha_o;
  logic                         last_of_frame_o;

  downscale_checker chk = new();

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;

  box_filter_downscaler #(
    .MAX_WIDTH      (LINE_DEPTH),
    .MAX_RATIO_LOG2 (RATIO_CAP)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_red_i         (in_red_i),
    .in_green_i       (in_green_i),
    .in_blue_i        (in_blue_i),
    .in_alpha_i       (in_alpha_i),
    .start_of_frame_i (start_of_frame_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_red_o        (out_red_o),
    .out_green_o      (out_green_o),
    .out_blue_o       (out_blue_o),
    .out_alpha_o      (out_alpha_o),
    .last_of_frame_o  (last_of_frame_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // receiver stalls, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_done != hold_asks) begin
      hold_left = HOLD_CYCLES;
      hold_done = hold_asks;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // output transfer monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      chk.match_pixel('{red: out_red_o, green: out_green_o, blue: out_blue_o,
                        alpha: out_alpha_o, lof: last_of_frame_o});
  end

  // run limit
  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic src_pix_t make_pixel(input logic [bfd_pkg::CH_W-1:0] r, g, b, a,
                                          input logic sof);
    make_pixel = '{red: r, green: g, blue: b, alpha: a, sof: sof};
  endfunction

  function automatic logic [bfd_pkg::CH_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return bfd_pkg::CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin gap_pct = 0;  stall_pct = 0;  end
      IDLE_SEND: begin gap_pct = 49; stall_pct = 0;  end
      IDLE_RECV: begin gap_pct = 0;  stall_pct = 49; end
      IDLE_BOTH: begin gap_pct = 27; stall_pct = 27; end
      default:   begin gap_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // one input transfer, entered and left at a falling edge
  task automatic send_pixel(input src_pix_t pix);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    in_red_i         <= pix.red;
    in_green_i       <= pix.green;
    in_blue_i        <= pix.blue;
    in_alpha_i       <= pix.alpha;
    start_of_frame_i <= pix.sof;
    do @(posedge clk_i); while (in_stall_o);
    chk.take_pixel(pix);
    @(negedge clk_i);
  endtask

  // random pixels, frame start on the first, optional stray frame starts
  task automatic stream(input int unsigned n, input int unsigned lo, input bit noise);
    int unsigned i;
    logic        sof;
    for (i = 0; i < n; i++) begin
      sof = (i == 0) || (noise && $urandom_range(0, 49) == 0);
      if (lo > 0)
        send_pixel(make_pixel(bfd_pkg::CH_W'($urandom_range(lo, 255)),
                              bfd_pkg::CH_W'($urandom_range(lo, 255)),
                              bfd_pkg::CH_W'($urandom_range(lo, 255)),
                              bfd_pkg::CH_W'($urandom_range(lo, 255)),
                              sof));
      else
        send_pixel(make_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(), sof));
    end
    in_valid_i <= 1'b0;
  endtask

  // wait for every expected mean, then for the pipeline to empty
  task automatic settle();
    while (chk.pending_means.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [bfd_pkg::REG_IDX_W-1:0] idx,
                           input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bfd_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= bfd_pkg::APB_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    chk.write_reg(idx, bfd_pkg::CFG_W'(value));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(input int unsigned w, h, r);
    settle();
    apb_write(bfd_pkg::REG_SRC_WIDTH, w);
    apb_write(bfd_pkg::REG_SRC_HEIGHT, h);
    apb_write(bfd_pkg::REG_RATIO_LOG2, r);
  endtask

  initial begin
    int unsigned phase, w, h, r, side, n;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero sizes count as one: every pixel is its own block and the frame end
    set_idling(IDLE_NONE);
    configure(0, 0, 0);
    send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1));
    send_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0));
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    in_valid_i <= 1'b0;

    // 2x2 blocks, full scale and one channel per pixel
    configure(2, 2, 1);
    repeat (4) send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_pixel(make_pixel(8'hFF, 8'h00, 8'h00, 8'h00, 1'b1));
    send_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 8'h00, 1'b0));
    send_pixel(make_pixel(8'h00, 8'h00, 8'hFF, 8'h00, 1'b0));
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0));
    in_valid_i <= 1'b0;

    // ratio above the cap and an image smaller than one block
    configure(3, 3, 7);
    stream(2, 0, 1'b0);

    // trailing column and row outside whole blocks
    configure(3, 3, 1);
    stream(9, 0, 1'b0);

    // widest line, one mean per pixel, long receiver hold-off
    set_idling(IDLE_NONE);
    configure(LINE_DEPTH, 2047, 0);
    hold_asks++;
    stream(100, 0, 1'b1);

    // 16x16 block with an ignored last row, bright pixels
    set_idling(IDLE_BOTH);
    configure(16, 17, 4);
    stream(272, 192, 1'b0);

    // random frame shapes across all idling modes
    for (phase = 0; phase < 6; phase++) begin
      set_idling(idle_mode_e'(phase % 4));
      r    = $urandom_range(0, 2);
      side = 1 << r;
      w    = side * $urandom_range(1, 3) + $urandom_range(0, side - 1);
      h    = side * $urandom_range(1, 2) + $urandom_range(0, side - 1);
      configure(w, h, r);
      n = w * h + $urandom_range(0, w);
      if (n > 40) n = 40;
      stream(n, 0, 1'b1);
    end

    settle();
    if (chk.fails == 0 && chk.pending_means.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
design/bfd_pkg.sv
design/bfd_pos.sv
design/bfd_accum.sv
design/box_filter_downscaler.sv
design/bfd_chk.sv
test/testbench.sv
